### hw/rtl/bpa_pkg.sv
// Package with the commands, status codes, sequencer states and result word of the page allocator.
package bpa_pkg;
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;
    localparam logic [1:0] CMD_TEST    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NORUN = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_DUP   = 2'd3;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MREAD = 3'd2;
    localparam logic [2:0] S_MWAIT = 3'd3;
    localparam logic [2:0] S_MWR   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] first_page;
        logic        page_used;
        logic [16:0] free_pages;
    } t_result;
endpackage

### hw/rtl/bpa_out_reg.sv
// Output register holding one result word under valid and stall.
module bpa_out_reg
    import bpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_empty,
    output t_result o_res
);
    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_empty = !r_valid || !i_stall;
    assign o_res   = r_res;
endmodule

### hw/rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: bitmap memory and command sequencer.
//
// Input words carry a command, a page and a count under i_valid / o_stall.
// Page bits are handled in turn by a shared compare and count unit.
// Results leave under o_valid / i_stall through an output register, so a
// new command is taken while the previous result still waits.
// After reset a clearing pass writes all ones into each bitmap word in
// turn; no command is taken meanwhile, config writes are.
// Allocate scans page by page from 0 up to the limit, reading each bitmap
// word as the scan enters it, then marks the run through the reserve path.
// Free and reserve read, check and write each page of the run in turn;
// test reads and checks a single page.
// A result leaves the register once i_stall is low; while the receiver
// stalls, a following command can still run but cannot complete into the
// output register until the previous result is taken.
// The page limit register is written over i_cfg_valid / o_cfg_ready.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 65536,
    parameter int WORD_BITS = 64,
    parameter int MAX_RUN   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_page,
    input  logic [8:0]  i_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_first_page,
    output logic        o_page_used,
    output logic [16:0] o_free_pages
);
    localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int PW    = ($clog2(NUM_PAGES + 1) > 17) ? $clog2(NUM_PAGES + 1) : 17;
    localparam int RW    = $clog2(MAX_RUN + 1);
    localparam logic [PW-1:0] NUM_PAGES_P = PW'(NUM_PAGES);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_word;
    logic [2:0]  r_state;
    logic [16:0] r_limit;
    logic [16:0] r_free;
    logic [1:0]  r_cmd;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_start;
    logic [RW-1:0] r_run;
    logic [RW-1:0] r_cnt;
    logic [RW-1:0] r_left;
    logic        r_bad, r_dup;
    logic [AW-1:0] r_clr;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic        do_mark;
    logic [AW-1:0] rd_addr;
    t_result     res;
    logic        load, oreg_empty;

    logic [PW-1:0] lim;
    assign lim = (32'(r_limit) < NUM_PAGES) ? PW'(r_limit) : NUM_PAGES_P;

    logic [BW-1:0] bit_i;
    logic          bit_v;
    assign bit_i = r_p[BW-1:0];
    assign bit_v = r_word[bit_i];

    assign rd_addr = AW'(r_p >> BW);

    logic in_rng;
    assign in_rng = (r_p < lim) && !(r_cmd == CMD_FREE && r_p == '0);

    assign do_mark   = (r_state == S_MWR) && (r_cmd != CMD_TEST) && in_rng &&
                       ((r_cmd == CMD_FREE) == bit_v);
    assign mem_we    = (r_state == S_CLEAR) || do_mark;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : rd_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? {WORD_BITS{1'b1}} :
                       (r_word ^ (WORD_BITS'(1) << bit_i));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 17'h10000;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_comb begin
        load = (r_state == S_DONE) && oreg_empty;
        res  = '0;
        res.free_pages = r_free;
        if (r_state == S_DONE) begin
            res.status     = r_cmd == CMD_ALLOC ? (r_bad ? ST_NORUN : ST_OK) :
                             r_cmd == CMD_TEST ? (r_bad ? ST_RANGE : ST_OK) :
                             r_bad ? ST_RANGE : (r_dup ? ST_DUP : ST_OK);
            res.first_page = (r_cmd == CMD_ALLOC && !r_bad) ? r_start[15:0] : 16'd0;
            res.page_used  = (r_cmd == CMD_TEST) ? r_dup : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_free  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_cmd  <= i_command;
                    r_bad  <= 1'b0;
                    r_dup  <= 1'b0;
                    r_run  <= '0;
                    r_cnt  <= RW'(i_count);
                    r_left <= RW'(i_count);
                    r_p    <= (i_command == CMD_ALLOC) ? '0 : PW'(i_page);
                    priority if (i_command == CMD_ALLOC &&
                                 (i_count == 9'd0 || 32'(i_count) > MAX_RUN)) begin
                        r_bad <= 1'b1;
                        r_state <= S_DONE;
                    end else if (i_command != CMD_ALLOC && i_command != CMD_TEST &&
                                 32'(i_count) > MAX_RUN) begin
                        r_bad <= 1'b1;
                        r_state <= S_DONE;
                    end else if (i_command != CMD_ALLOC && i_command != CMD_TEST &&
                                 i_count == 9'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MREAD;
                    end
                end
                S_SCAN: begin
                    if (r_p >= lim) begin
                        r_bad   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (bit_v) begin
                        r_run <= '0;
                        r_p   <= r_p + PW'(1);
                        if (&r_p[BW-1:0]) r_state <= S_MREAD;
                    end else if (r_run + RW'(1) == r_cnt) begin
                        r_start <= r_p + PW'(1) - PW'(r_cnt);
                        r_p     <= r_p + PW'(1) - PW'(r_cnt);
                        r_cmd   <= CMD_RESERVE;
                        r_left  <= r_cnt;
                        r_state <= S_MREAD;
                    end else begin
                        r_run <= r_run + RW'(1);
                        r_p   <= r_p + PW'(1);
                        if (&r_p[BW-1:0]) r_state <= S_MREAD;
                    end
                end
                S_MREAD: r_state <= S_MWAIT;
                S_MWAIT: begin
                    r_word  <= r_rdata;
                    r_state <= (r_cmd == CMD_ALLOC) ? S_SCAN : S_MWR;
                end
                S_MWR: begin
                    if (r_cmd == CMD_TEST) begin
                        if (r_p >= lim) begin
                            r_bad <= 1'b1;
                            r_dup <= 1'b1;
                        end else begin
                            r_dup <= bit_v;
                        end
                        r_state <= S_DONE;
                    end else begin
                        if (!in_rng) begin
                            r_bad <= 1'b1;
                        end else if ((r_cmd == CMD_FREE) != bit_v) begin
                            r_dup <= 1'b1;
                        end else begin
                            if (r_cmd == CMD_FREE) begin
                                if (r_free != COUNT_MAX) r_free <= r_free + 17'd1;
                            end else if (r_free != 17'd0) begin
                                r_free <= r_free - 17'd1;
                            end
                        end
                        r_p    <= r_p + PW'(1);
                        r_left <= r_left - RW'(1);
                        r_state <= (r_left == RW'(1)) ? S_DONE : S_MREAD;
                    end
                end
                S_DONE: begin
                    if (oreg_empty) begin
                        r_state <= S_IDLE;
                        if (r_cmd == CMD_RESERVE && r_start != '0) begin
                            r_start <= r_start;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // An allocation is marked through the reserve path; keep its status and
    // first page by remembering it in a flag.
    logic r_alloc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= 1'b0;
        end else if (r_state == S_IDLE && i_valid) begin
            r_alloc <= (i_command == CMD_ALLOC);
        end
    end

    t_result res_f;
    always_comb begin
        res_f = res;
        if (r_alloc) begin
            res_f.status     = r_bad ? ST_NORUN : ST_OK;
            res_f.first_page = r_bad ? 16'd0 : r_start[15:0];
            res_f.page_used  = 1'b0;
        end
    end

    t_result ores;
    bpa_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res_f),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_empty (oreg_empty),
        .o_res   (ores)
    );

    assign o_status     = ores.status;
    assign o_first_page = ores.first_page;
    assign o_page_used  = ores.page_used;
    assign o_free_pages = ores.free_pages;
endmodule
